@@ rtl/core/clex_pkg.sv @@
// ----------------------------------------------------------------------------
// clex_pkg
// Shared types, codes and keyword tables for the C subset lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package clex_pkg;

    localparam int MAX_TOKEN_LEN_DEF = 19;
    localparam int KW_COUNT          = 9;
    localparam int KW_POS            = 8;

    typedef enum logic [2:0] {
        KIND_KEYWORD   = 3'd0,
        KIND_IDENT     = 3'd1,
        KIND_NUMBER    = 3'd2,
        KIND_OPERATOR  = 3'd3,
        KIND_SEPARATOR = 3'd4,
        KIND_END       = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2,
        MODE_EQ     = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        CLS_WORD,
        CLS_DIGIT,
        CLS_EQ,
        CLS_OP,
        CLS_PUNCT,
        CLS_SKIP
    } t_cls;

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_APPEND,
        TAIL_EMIT,
        TAIL_END
    } t_tail;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_FLUSH,
        ST_TAIL
    } t_state;

    typedef enum logic [1:0] {
        OSRC_BUF,
        OSRC_BYTE,
        OSRC_END
    } t_out_src;

    typedef struct packed {
        logic     load_in;
        logic     append;
        logic     flush_adv;
        logic     clear_tok;
        logic     out_load;
        t_out_src out_src;
        t_kind    out_kind;
        logic     out_last;
    } t_dp_cmd;

    typedef struct packed {
        t_cls cls;
        logic eot;
        logic is_kw;
        logic flush_last;
        logic out_free;
    } t_dp_sts;

    localparam logic [7:0] KW_CHR [KW_COUNT][KW_POS] = '{
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
        '{"d", "o", "u", "b", "l", "e", 8'h00, 8'h00}
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd6, 4'd2, 4'd4, 4'd5, 4'd3, 4'd4, 4'd5, 4'd6
    };

    function automatic t_cls classify(input logic [7:0] c);
        logic letter;
        logic digit;
        letter = (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
        digit  = (c inside {[8'h30:8'h39]});
        if (letter || c == 8'h5F) begin
            return CLS_WORD;
        end else if (digit) begin
            return CLS_DIGIT;
        end else if (c == 8'h3D) begin
            return CLS_EQ;
        end else if (c inside {8'h2B, 8'h2D, 8'h2A, 8'h2F}) begin
            return CLS_OP;
        end else if (c inside {[8'h21:8'h7E]}) begin
            return CLS_PUNCT;
        end
        return CLS_SKIP;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/clex_dpath.sv @@
// ----------------------------------------------------------------------------
// clex_dpath
// Token buffer, length and keyword match tracking, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module clex_dpath #(
    parameter int MAX_TOKEN_LEN = clex_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_text_byte,
    input  logic              i_end_of_text,
    input  clex_pkg::t_dp_cmd i_cmd,
    output clex_pkg::t_dp_sts o_sts,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [2:0]        o_token_kind,
    output logic [7:0]        o_token_char,
    output logic              o_token_done,
    output logic              o_token_truncated,
    output logic              o_run_last
);
    import clex_pkg::*;

    localparam int AW = $clog2(MAX_TOKEN_LEN);
    localparam int LW = $clog2(MAX_TOKEN_LEN + 1);

    logic [7:0]          r_mem [MAX_TOKEN_LEN];
    logic [7:0]          r_rd;
    logic [7:0]          r_byte;
    logic                r_eot;
    logic [LW-1:0]       r_len, n_len;
    logic                r_ovf, n_ovf;
    logic [AW-1:0]       r_idx, n_idx;
    logic [AW-1:0]       rd_addr;
    logic [KW_COUNT-1:0] r_match, n_match;
    logic [KW_COUNT-1:0] kw_hit;
    logic                room;
    logic                flush_last;
    logic                out_free;

    logic                r_out_valid;
    logic [2:0]          r_kind;
    logic [7:0]          r_char;
    logic                r_done;
    logic                r_trunc;
    logic                r_last;

    assign room       = r_len < LW'(MAX_TOKEN_LEN);
    assign flush_last = (LW'(r_idx) + LW'(1)) == r_len;
    assign out_free   = !r_out_valid || i_out_ready;
    assign rd_addr    = (i_cmd.flush_adv && !flush_last) ? r_idx + AW'(1) : r_idx;

    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            kw_hit[k] = r_match[k] && (r_len == LW'(KW_LEN[k]));
        end
    end

    always_comb begin
        o_sts.cls        = classify(r_byte);
        o_sts.eot        = r_eot;
        o_sts.is_kw      = !r_ovf && (|kw_hit);
        o_sts.flush_last = flush_last;
        o_sts.out_free   = out_free;
    end

    always_comb begin
        n_len   = r_len;
        n_ovf   = r_ovf;
        n_idx   = r_idx;
        n_match = r_match;
        if (i_cmd.clear_tok) begin
            n_len   = '0;
            n_ovf   = 1'b0;
            n_idx   = '0;
            n_match = '1;
        end else begin
            if (i_cmd.append) begin
                if (room) begin
                    n_len = r_len + LW'(1);
                    for (int k = 0; k < KW_COUNT; k++) begin
                        n_match[k] = r_match[k] && (r_len < LW'(KW_LEN[k]))
                                     && (KW_CHR[k][r_len[2:0]] == r_byte);
                    end
                end else begin
                    n_ovf = 1'b1;
                end
            end
            if (i_cmd.flush_adv) begin
                n_idx = r_idx + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_idx   <= '0;
            r_match <= '1;
        end else begin
            r_len   <= n_len;
            r_ovf   <= n_ovf;
            r_idx   <= n_idx;
            r_match <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && room) begin
            r_mem[r_len[AW-1:0]] <= r_byte;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_byte <= i_text_byte;
            r_eot  <= i_end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_kind <= i_cmd.out_kind;
            r_last <= i_cmd.out_last;
            case (i_cmd.out_src)
                OSRC_BUF: begin
                    r_char  <= r_rd;
                    r_done  <= flush_last;
                    r_trunc <= r_ovf;
                end
                OSRC_BYTE: begin
                    r_char  <= r_byte;
                    r_done  <= 1'b1;
                    r_trunc <= 1'b0;
                end
                default: begin
                    r_char  <= 8'h00;
                    r_done  <= 1'b1;
                    r_trunc <= 1'b0;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_token_kind      = r_kind;
    assign o_token_char      = r_char;
    assign o_token_done      = r_done;
    assign o_token_truncated = r_trunc;
    assign o_run_last        = r_last;

endmodule

`default_nettype wire

@@ rtl/core/clex_ctrl.sv @@
// ----------------------------------------------------------------------------
// clex_ctrl
// Lexer state machine: decodes each byte and sequences token flushes.
// ----------------------------------------------------------------------------
`default_nettype none

module clex_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  clex_pkg::t_dp_sts i_sts,
    output clex_pkg::t_dp_cmd o_cmd
);
    import clex_pkg::*;

    t_state r_state, n_state;
    t_mode  r_mode,  n_mode;
    t_tail  r_tail,  n_tail;
    t_kind  r_fkind, n_fkind;

    logic   cont;
    t_kind  pend_kind;
    t_tail  start_tail;
    t_mode  start_mode;

    always_comb begin
        case (i_sts.cls)
            CLS_WORD, CLS_DIGIT, CLS_EQ: start_tail = TAIL_APPEND;
            CLS_OP, CLS_PUNCT:           start_tail = TAIL_EMIT;
            default:                     start_tail = TAIL_NONE;
        endcase
        case (i_sts.cls)
            CLS_WORD:  start_mode = MODE_IDENT;
            CLS_DIGIT: start_mode = MODE_NUMBER;
            CLS_EQ:    start_mode = MODE_EQ;
            default:   start_mode = MODE_START;
        endcase
        case (r_mode)
            MODE_IDENT:  pend_kind = i_sts.is_kw ? KIND_KEYWORD : KIND_IDENT;
            MODE_NUMBER: pend_kind = KIND_NUMBER;
            default:     pend_kind = KIND_OPERATOR;
        endcase
        cont = (r_mode == MODE_IDENT && (i_sts.cls == CLS_WORD || i_sts.cls == CLS_DIGIT))
               || (r_mode == MODE_NUMBER && i_sts.cls == CLS_DIGIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= MODE_START;
            r_tail  <= TAIL_NONE;
            r_fkind <= KIND_OPERATOR;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_tail  <= n_tail;
            r_fkind <= n_fkind;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_tail     = r_tail;
        n_fkind    = r_fkind;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_fkind = pend_kind;
                if (i_sts.eot) begin
                    n_tail  = TAIL_END;
                    n_state = (r_mode != MODE_START) ? ST_FLUSH : ST_TAIL;
                end else if (cont) begin
                    o_cmd.append = 1'b1;
                    n_state      = ST_IDLE;
                end else if (r_mode == MODE_EQ && i_sts.cls == CLS_EQ) begin
                    o_cmd.append = 1'b1;
                    n_tail       = TAIL_NONE;
                    n_state      = ST_FLUSH;
                end else if (r_mode != MODE_START) begin
                    n_tail  = start_tail;
                    n_state = ST_FLUSH;
                end else begin
                    case (start_tail)
                        TAIL_APPEND: begin
                            o_cmd.append = 1'b1;
                            n_mode       = start_mode;
                            n_state      = ST_IDLE;
                        end
                        TAIL_EMIT: begin
                            n_tail  = TAIL_EMIT;
                            n_state = ST_TAIL;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_src   = OSRC_BUF;
                    o_cmd.out_kind  = r_fkind;
                    o_cmd.flush_adv = 1'b1;
                    if (i_sts.flush_last) begin
                        o_cmd.clear_tok = 1'b1;
                        o_cmd.out_last  = (r_tail == TAIL_NONE) || (r_tail == TAIL_APPEND);
                        n_mode          = MODE_START;
                        n_state         = (r_tail == TAIL_NONE) ? ST_IDLE : ST_TAIL;
                    end
                end
            end
            ST_TAIL: begin
                case (r_tail)
                    TAIL_APPEND: begin
                        o_cmd.append = 1'b1;
                        n_mode       = start_mode;
                        n_state      = ST_IDLE;
                    end
                    TAIL_EMIT: begin
                        if (i_sts.out_free) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_src  = OSRC_BYTE;
                            o_cmd.out_kind = (i_sts.cls == CLS_OP) ? KIND_OPERATOR
                                                                   : KIND_SEPARATOR;
                            o_cmd.out_last = 1'b1;
                            n_state        = ST_IDLE;
                        end
                    end
                    TAIL_END: begin
                        if (i_sts.out_free) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_src  = OSRC_END;
                            o_cmd.out_kind = KIND_END;
                            o_cmd.out_last = 1'b1;
                            n_mode         = MODE_START;
                            n_state        = ST_IDLE;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/c_subset_lexer_top.sv @@
// ----------------------------------------------------------------------------
// c_subset_lexer_top
// Byte-serial lexer for a small C subset, one result per token character.
// ----------------------------------------------------------------------------
// A byte that extends the pending token, starts a new one from the start mode
// or is skipped passes through the decide state before the next ready. A byte
// that closes a token holds off the next byte while the token text leaves the
// buffer through its single read port, one character per cycle while the
// output register is free. The tail state follows when the byte is itself a
// one-character operator or separator, starts the next token after a flush,
// or ends the text, for the end token. Results leave through an output
// register that holds while the consumer stalls; while a full output register
// waits on the consumer, the flush and the emitting tail steps wait too.
`default_nettype none

module c_subset_lexer_top #(
    parameter int MAX_TOKEN_LEN = clex_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_token_kind,
    output logic [7:0] o_token_char,
    output logic       o_token_done,
    output logic       o_token_truncated,
    output logic       o_run_last
);
    import clex_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    clex_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    clex_dpath #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_text_byte       (i_text_byte),
        .i_end_of_text     (i_end_of_text),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_token_kind      (o_token_kind),
        .o_token_char      (o_token_char),
        .o_token_done      (o_token_done),
        .o_token_truncated (o_token_truncated),
        .o_run_last        (o_run_last)
    );

endmodule

`default_nettype wire

@@ rtl/core/clex_checker.sv @@
// ----------------------------------------------------------------------------
// clex_checker
// Port-level checks on the lexer result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module clex_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [2:0] o_token_kind,
    input logic [7:0] o_token_char,
    input logic       o_token_done,
    input logic       o_token_truncated,
    input logic       o_run_last
);
    import clex_pkg::*;

    a_end_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_token_kind == KIND_END) |->
        (o_token_char == 8'h00 && o_token_done && !o_token_truncated && o_run_last))
        else $error("end token carries wrong fields");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_run_last) |-> o_token_done)
        else $error("last result of a transfer is not the end of a token");

    a_sep_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_token_kind == KIND_SEPARATOR || o_token_kind == KIND_END))
        |-> o_token_done)
        else $error("separator longer than one character");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_token_kind) && $stable(o_token_char)
         && $stable(o_token_done) && $stable(o_token_truncated) && $stable(o_run_last)))
        else $error("stalled result changed");

endmodule

bind c_subset_lexer_top clex_checker u_clex_checker (.*);

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte-serial C subset lexer.
// A queue of source bytes feeds a clocked driver that sends in bursts with
// gaps. A clocked monitor lexes every transferred byte in its own model and
// compares each token character that leaves the block, field by field.
// Directed text covers keywords, "==", a held '=' before another byte, end of
// text with and without a pending token, and skipped bytes. Random text with
// long tokens follows. The receiver stalls on changing patterns, with two
// long hold-offs.
// ----------------------------------------------------------------------------

module tb;
    import clex_pkg::*;

    localparam int         TOK_MAX    = MAX_TOKEN_LEN_DEF;
    localparam logic [7:0] CH_EQ      = "=";
    localparam logic [7:0] CH_US      = "_";
    localparam int         TEXT_ITEMS = 430;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic       drain;
    } t_text_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic       done;
        logic       trunc;
        logic       last;
    } t_tok_char;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_text_byte = 8'h00;
    logic       i_end_of_text = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [2:0] o_token_kind;
    logic [7:0] o_token_char;
    logic       o_token_done;
    logic       o_token_truncated;
    logic       o_run_last;

    t_text_item text_items [$];
    t_tok_char  token_chars_due [$];

    string keywords [9] = '{"int", "return", "if", "else", "while", "for", "char", "float",
                            "double"};

    t_mode      lx_mode = MODE_START;
    logic [7:0] lx_buf [TOK_MAX];
    int         lx_len = 0;
    logic       lx_ovf = 1'b0;

    logic in_fired = 1'b0;
    int   items_taken = 0;
    int   mismatches = 0;
    int   n_counted = 0;
    int   gap_left = 0;
    int   burst_left = 0;
    int   rx_hold = 0;
    int   rx_holds_done = 0;
    int   rx_regime = 0;
    int   rx_cycle = 0;

    c_subset_lexer_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_text_byte      (i_text_byte),
        .i_end_of_text    (i_end_of_text),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_token_kind     (o_token_kind),
        .o_token_char     (o_token_char),
        .o_token_done     (o_token_done),
        .o_token_truncated(o_token_truncated),
        .o_run_last       (o_run_last)
    );

    always #2 i_clk = ~i_clk;

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_word_char(input logic [7:0] c);
        return is_letter(c) || is_digit(c) || c == CH_US;
    endfunction

    // ---- token model -------------------------------------------------------

    function automatic void buffer_char(input logic [7:0] c);
        if (lx_len < TOK_MAX) begin
            lx_buf[lx_len] = c;
            lx_len++;
        end else begin
            lx_ovf = 1'b1;
        end
    endfunction

    function automatic bit held_is_keyword();
        bit same;
        if (lx_ovf) return 1'b0;
        foreach (keywords[k]) begin
            if (keywords[k].len() == lx_len) begin
                same = 1'b1;
                for (int i = 0; i < lx_len; i++)
                    if (lx_buf[i] != keywords[k][i]) same = 1'b0;
                if (same) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_kind held_kind();
        if (lx_mode == MODE_IDENT) return held_is_keyword() ? KIND_KEYWORD : KIND_IDENT;
        if (lx_mode == MODE_NUMBER) return KIND_NUMBER;
        return KIND_OPERATOR;
    endfunction

    function automatic void emit_token(input t_kind kind);
        for (int i = 0; i < lx_len; i++)
            token_chars_due.push_back('{kind, lx_buf[i], i == lx_len - 1, lx_ovf, 1'b0});
        lx_len  = 0;
        lx_ovf  = 1'b0;
        lx_mode = MODE_START;
    endfunction

    function automatic void lex_byte(input logic [7:0] c, input logic eot);
        int        first;
        bit        taken;
        t_tok_char tail;
        first = token_chars_due.size();
        taken = 1'b0;
        if (eot) begin
            if (lx_mode != MODE_START) emit_token(held_kind());
            token_chars_due.push_back('{KIND_END, 8'h00, 1'b1, 1'b0, 1'b0});
        end else begin
            case (lx_mode)
                MODE_EQ: begin
                    if (c == CH_EQ) begin
                        buffer_char(c);
                        taken = 1'b1;
                    end
                    emit_token(KIND_OPERATOR);
                end
                MODE_IDENT: begin
                    if (is_word_char(c)) begin
                        buffer_char(c);
                        taken = 1'b1;
                    end else begin
                        emit_token(held_kind());
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit(c)) begin
                        buffer_char(c);
                        taken = 1'b1;
                    end else begin
                        emit_token(KIND_NUMBER);
                    end
                end
                default: ;
            endcase
            if (!taken) begin
                if (is_letter(c) || c == CH_US) begin
                    buffer_char(c);
                    lx_mode = MODE_IDENT;
                end else if (is_digit(c)) begin
                    buffer_char(c);
                    lx_mode = MODE_NUMBER;
                end else if (c == CH_EQ) begin
                    buffer_char(c);
                    lx_mode = MODE_EQ;
                end else if (c inside {"+", "-", "*", "/"}) begin
                    buffer_char(c);
                    emit_token(KIND_OPERATOR);
                end else if (c >= 8'd33 && c <= 8'd126) begin
                    buffer_char(c);
                    emit_token(KIND_SEPARATOR);
                end
            end
        end
        if (token_chars_due.size() > first) begin
            tail      = token_chars_due.pop_back();
            tail.last = 1'b1;
            token_chars_due.push_back(tail);
        end
    endfunction

    // ---- stimulus ----------------------------------------------------------

    function automatic void push_byte(input logic [7:0] c, input logic eot);
        text_items.push_back('{c, eot, 1'b0});
        n_counted++;
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
    endfunction

    function automatic void push_drain();
        text_items.push_back('{8'h00, 1'b0, 1'b1});
    endfunction

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        if (r < 26) return 8'(8'h61 + r);
        return 8'(8'h41 + r - 26);
    endfunction

    function automatic logic [7:0] rand_word_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 52) return rand_letter();
        if (r < 62) return 8'(8'h30 + r - 52);
        return CH_US;
    endfunction

    function automatic logic [7:0] rand_punct();
        logic [7:0] c;
        c = 8'($urandom_range(33, 126));
        while (is_letter(c) || is_digit(c) || c == CH_EQ || c inside {"+", "-", "*", "/"})
            c = 8'($urandom_range(33, 126));
        return c;
    endfunction

    function automatic logic [7:0] rand_skip();
        case ($urandom_range(0, 3))
            0: return 8'h20;
            1: return 8'($urandom_range(0, 32));
            2: return 8'h7F;
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    function automatic int rand_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 8);
    endfunction

    function automatic void push_random_token();
        int    len;
        int    r;
        string kw;
        r = $urandom_range(0, 99);
        if (r < 14) begin
            kw = keywords[$urandom_range(0, 8)];
            if ($urandom_range(0, 4) == 0) kw = kw.substr(0, kw.len() - 2);
            push_text(kw);
            if ($urandom_range(0, 4) == 0) push_byte(rand_word_char(), 1'b0);
        end else if (r < 36) begin
            len = rand_len();
            push_byte(($urandom_range(0, 7) == 0) ? CH_US : rand_letter(), 1'b0);
            for (int i = 1; i < len; i++) push_byte(rand_word_char(), 1'b0);
        end else if (r < 52) begin
            len = rand_len();
            for (int i = 0; i < len; i++) push_byte(8'($urandom_range(8'h30, 8'h39)), 1'b0);
        end else if (r < 62) begin
            case ($urandom_range(0, 5))
                0: push_text("+");
                1: push_text("-");
                2: push_text("*");
                3: push_text("/");
                4: push_text("==");
                default: push_text("=");
            endcase
        end else if (r < 72) begin
            push_byte(rand_punct(), 1'b0);
        end else if (r < 84) begin
            push_byte(rand_skip(), 1'b0);
        end else if (r < 94) begin
            push_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (r < 97) begin
            push_byte(8'($urandom_range(0, 255)), 1'b1);
        end
        if ($urandom_range(0, 1) == 0) push_byte(rand_skip(), 1'b0);
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // ---- driver ------------------------------------------------------------

    always @(negedge i_clk) begin
        t_text_item item;
        if (i_rst_n && (!i_in_valid || in_fired)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (text_items.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (text_items[0].drain) begin
                i_in_valid <= 1'b0;
                if (token_chars_due.size() == 0) void'(text_items.pop_front());
            end else begin
                item = text_items.pop_front();
                i_in_valid    <= 1'b1;
                i_text_byte   <= item.ch;
                i_end_of_text <= item.eot;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // ---- receiver ----------------------------------------------------------

    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 50 == 0) rx_regime = $urandom_range(0, 3);
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            i_out_ready <= 1'b0;
        end else if (rx_holds_done < 2 && items_taken >= 120 + rx_holds_done * 200) begin
            rx_hold = 400;
            rx_holds_done++;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_regime)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 3) != 0);
                2: i_out_ready <= rx_cycle[0];
                default: i_out_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // ---- monitor -----------------------------------------------------------

    always @(posedge i_clk) begin
        t_tok_char want;
        in_fired <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (token_chars_due.size() == 0) begin
                $display("%0t: unexpected token char, expected none, actual kind %0d char %0h",
                         $time, o_token_kind, o_token_char);
                mismatches++;
            end else begin
                want = token_chars_due.pop_front();
                check_field("token_kind", 8'(want.kind), 8'(o_token_kind));
                check_field("token_char", want.ch, o_token_char);
                check_field("token_done", 8'(want.done), 8'(o_token_done));
                check_field("token_truncated", 8'(want.trunc), 8'(o_token_truncated));
                check_field("run_last", 8'(want.last), 8'(o_run_last));
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            lex_byte(i_text_byte, i_end_of_text);
            items_taken++;
        end
    end

    // ---- sequence ----------------------------------------------------------

    initial begin
        bit mid_drain;
        mid_drain = 1'b0;

        push_text("int _x==9+-*/;");
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_text("=b");
        push_byte(8'hA5, 1'b1);
        push_byte(8'h00, 1'b1);
        push_text("7");
        push_byte(8'h5A, 1'b1);
        push_text("=");
        push_byte(8'hFF, 1'b1);
        push_drain();

        while (n_counted < TEXT_ITEMS) begin
            push_random_token();
            if (!mid_drain && n_counted >= 250) begin
                push_drain();
                mid_drain = 1'b1;
            end
        end
        push_byte(8'($urandom_range(0, 255)), 1'b1);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (text_items.size() != 0 || i_in_valid) @(posedge i_clk);
        while (token_chars_due.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/clex_pkg.sv
rtl/core/clex_dpath.sv
rtl/core/clex_ctrl.sv
rtl/core/c_subset_lexer_top.sv
rtl/core/clex_checker.sv
tb/tb.sv
